// ===== src/bctc_pkg.sv =====
// shared types and constants for the config token checker
`default_nettype none

package bctc_pkg;

  localparam int unsigned LevelW = 5;
  localparam logic [LevelW-1:0] MAX_DEPTH = 5'd16;
  localparam logic [LevelW-1:0] DEPTH_LIMIT_RST = 5'd16;

  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;

  typedef enum logic [2:0] {
    KIND_ID    = 3'd0,
    KIND_STR   = 3'd1,
    KIND_SEMI  = 3'd2,
    KIND_OPEN  = 3'd3,
    KIND_CLOSE = 3'd4,
    KIND_EOF   = 3'd5
  } token_kind_e;

  typedef enum logic [3:0] {
    ROLE_DIRECTIVE = 4'd0,
    ROLE_ARG       = 4'd1,
    ROLE_MAP_WORD  = 4'd2,
    ROLE_MAP_KEY   = 4'd3,
    ROLE_MAP_VAL   = 4'd4,
    ROLE_INC_WORD  = 4'd5,
    ROLE_INC_TGT   = 4'd6,
    ROLE_OPEN      = 4'd7,
    ROLE_CLOSE     = 4'd8,
    ROLE_SEMI      = 4'd9,
    ROLE_END       = 4'd10
  } role_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       map_word;
    logic       inc_word;
  } token_t;

  typedef struct packed {
    role_e             role;
    logic [LevelW-1:0] depth;
    status_e           status;
    logic              finished;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bctc_regs.sv =====
// apb register block holding the nesting depth limit
`default_nettype none

module bctc_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bctc_pkg::PaddrW-1:0]  paddr,
  input  wire logic [bctc_pkg::PdataW-1:0]  pwdata,
  output logic      [bctc_pkg::PdataW-1:0]  prdata,
  output logic                              pready,
  output logic      [bctc_pkg::LevelW-1:0]  depth_limit_o
);

  logic [bctc_pkg::LevelW-1:0] depth_limit_q;
  logic [bctc_pkg::LevelW-1:0] depth_limit_d;
  logic                        wr_en;

  // only one register, so every address selects it
  assign wr_en = psel && penable && pwrite && (paddr == paddr);

  always_comb begin
    depth_limit_d = depth_limit_q;
    if (wr_en) begin
      depth_limit_d = pwdata[bctc_pkg::LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= bctc_pkg::DEPTH_LIMIT_RST;
    end else begin
      depth_limit_q <= depth_limit_d;
    end
  end

  assign pready        = 1'b1;
  assign prdata        = {{(bctc_pkg::PdataW-bctc_pkg::LevelW){1'b0}}, depth_limit_q};
  assign depth_limit_o = depth_limit_q;

endmodule

`default_nettype wire

// ===== src/bctc_parse.sv =====
// grammar state machine: phase, nesting level and halt state
`default_nettype none

module bctc_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire bctc_pkg::token_t            token_i,
  input  wire logic [bctc_pkg::LevelW-1:0] depth_limit_i,
  output bctc_pkg::result_t                result_o
);

  typedef enum logic [3:0] {
    PH_CMD      = 4'd0,
    PH_ARGS     = 4'd1,
    PH_MAP_NAME = 4'd2,
    PH_MAP_ID   = 4'd3,
    PH_MAP_OPEN = 4'd4,
    PH_MAP_KEY  = 4'd5,
    PH_MAP_VAL  = 4'd6,
    PH_MAP_SEMI = 4'd7,
    PH_MAP_MORE = 4'd8,
    PH_INC_TGT  = 4'd9,
    PH_INC_SEMI = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    H_RUN = 2'd0,
    H_FIN = 2'd1,
    H_ERR = 2'd2
  } halt_e;

  phase_e                      phase_q, phase_d;
  halt_e                       halt_q, halt_d;
  logic [bctc_pkg::LevelW-1:0] level_q, level_d;
  logic [bctc_pkg::LevelW-1:0] eff_limit;
  logic                        word, is_id, is_semi, is_open, is_close, is_eof;
  logic                        err, at_limit;
  bctc_pkg::role_e             role;
  bctc_pkg::status_e           status;

  assign eff_limit = (depth_limit_i > bctc_pkg::MAX_DEPTH) ? bctc_pkg::MAX_DEPTH
                                                           : depth_limit_i;
  assign at_limit  = (level_q >= eff_limit);

  assign is_id    = (token_i.kind == bctc_pkg::KIND_ID);
  assign word     = is_id || (token_i.kind == bctc_pkg::KIND_STR);
  assign is_semi  = (token_i.kind == bctc_pkg::KIND_SEMI);
  assign is_open  = (token_i.kind == bctc_pkg::KIND_OPEN);
  assign is_close = (token_i.kind == bctc_pkg::KIND_CLOSE);
  assign is_eof   = (token_i.kind == bctc_pkg::KIND_EOF);

  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    halt_d  = halt_q;
    role    = bctc_pkg::ROLE_DIRECTIVE;
    status  = bctc_pkg::ST_OK;
    err     = 1'b0;
    if (halt_q != H_RUN) begin
      status = bctc_pkg::ST_IGNORED;
    end else begin
      case (phase_q)
        PH_CMD: begin
          if (is_id) begin
            if (token_i.map_word) begin
              role    = bctc_pkg::ROLE_MAP_WORD;
              phase_d = PH_MAP_NAME;
            end else if (token_i.inc_word) begin
              role    = bctc_pkg::ROLE_INC_WORD;
              phase_d = PH_INC_TGT;
            end else begin
              role    = bctc_pkg::ROLE_DIRECTIVE;
              phase_d = PH_ARGS;
            end
          end else if (is_close && (level_q != '0)) begin
            role    = bctc_pkg::ROLE_CLOSE;
            level_d = level_q - 1'b1;
          end else if (is_eof && (level_q == '0)) begin
            role   = bctc_pkg::ROLE_END;
            halt_d = H_FIN;
          end else begin
            err = 1'b1;
          end
        end
        PH_ARGS: begin
          if (word) begin
            role = bctc_pkg::ROLE_ARG;
          end else if (is_semi) begin
            role    = bctc_pkg::ROLE_SEMI;
            phase_d = PH_CMD;
          end else if (is_open) begin
            role = bctc_pkg::ROLE_OPEN;
            if (at_limit) begin
              status = bctc_pkg::ST_OVERFLOW;
              halt_d = H_ERR;
            end else begin
              level_d = level_q + 1'b1;
              phase_d = PH_CMD;
            end
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_NAME: begin
          if (word) begin
            role    = bctc_pkg::ROLE_ARG;
            phase_d = PH_MAP_ID;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_ID: begin
          if (is_id) begin
            role    = bctc_pkg::ROLE_ARG;
            phase_d = PH_MAP_OPEN;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_OPEN: begin
          if (is_open) begin
            role = bctc_pkg::ROLE_OPEN;
            if (at_limit) begin
              status = bctc_pkg::ST_OVERFLOW;
              halt_d = H_ERR;
            end else begin
              level_d = level_q + 1'b1;
              phase_d = PH_MAP_KEY;
            end
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_KEY: begin
          if (word) begin
            role    = bctc_pkg::ROLE_MAP_KEY;
            phase_d = PH_MAP_VAL;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_VAL: begin
          if (word) begin
            role    = bctc_pkg::ROLE_MAP_VAL;
            phase_d = PH_MAP_SEMI;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_SEMI: begin
          if (is_semi) begin
            role    = bctc_pkg::ROLE_SEMI;
            phase_d = PH_MAP_MORE;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAP_MORE: begin
          if (word) begin
            role    = bctc_pkg::ROLE_MAP_KEY;
            phase_d = PH_MAP_VAL;
          end else if (is_close && (level_q != '0)) begin
            role    = bctc_pkg::ROLE_CLOSE;
            level_d = level_q - 1'b1;
            phase_d = PH_CMD;
          end else begin
            err = 1'b1;
          end
        end
        PH_INC_TGT: begin
          if (word) begin
            role    = bctc_pkg::ROLE_INC_TGT;
            phase_d = PH_INC_SEMI;
          end else begin
            err = 1'b1;
          end
        end
        PH_INC_SEMI: begin
          if (is_semi) begin
            role    = bctc_pkg::ROLE_SEMI;
            phase_d = PH_CMD;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      // any syntax error wipes the role and halts until reset
      if (err) begin
        role    = bctc_pkg::ROLE_DIRECTIVE;
        status  = bctc_pkg::ST_SYNTAX;
        halt_d  = H_ERR;
        phase_d = phase_q;
        level_d = level_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      level_q <= '0;
      halt_q  <= H_RUN;
    end else if (adv_i) begin
      phase_q <= phase_d;
      level_q <= level_d;
      halt_q  <= halt_d;
    end
  end

  assign result_o.role     = role;
  assign result_o.depth    = level_d;
  assign result_o.status   = status;
  assign result_o.finished = (halt_d == H_FIN);

endmodule

`default_nettype wire

// ===== src/block_config_token_checker.sv =====
// config token checker: takes one lexer token a beat and checks the grammar
//
// input channel: token_kind_i, is_map_word_i, is_include_word_i, taken at an
// edge where in_valid_i is high and in_stall_o is low. every token gives
// exactly one result beat on token_role_o, nest_depth_o, status_o and
// finished_o, taken where out_valid_o is high and out_stall_i is low.
// a token passes the input register, then the grammar step into the result
// register. throughput is one token a cycle while out_stall_i is low, with
// the phase and level update done between the two registers.
// when the receiver stalls, the result register holds and the input register
// keeps one more token; only then is in_stall_o raised.
// reset clears both valid flags, puts the grammar in command start at depth
// zero and running, and sets depth_limit to 16. the first syntax error or
// depth overflow halts it and an end of file at depth zero finishes it, then
// every token reports ignored until reset. depth_limit is written over apb,
// every paddr selecting it; the user must write it only while idle (unenforced).
`default_nettype none

module block_config_token_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  token_kind_i,
  input  wire logic                        is_map_word_i,
  input  wire logic                        is_include_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [3:0]                  token_role_o,
  output logic      [4:0]                  nest_depth_o,
  output logic      [1:0]                  status_o,
  output logic                             finished_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bctc_pkg::PaddrW-1:0] paddr,
  input  wire logic [bctc_pkg::PdataW-1:0] pwdata,
  output logic      [bctc_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  logic                        tok_valid_q;
  bctc_pkg::token_t            tok_q;
  logic                        res_valid_q;
  bctc_pkg::result_t           res_q;
  bctc_pkg::result_t           res_d;
  logic                        res_ready;
  logic                        adv;
  logic                        in_take;
  logic [bctc_pkg::LevelW-1:0] depth_limit;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign adv        = tok_valid_q && res_ready;
  assign in_stall_o = tok_valid_q && !res_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  bctc_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .depth_limit_o (depth_limit)
  );

  bctc_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .token_i       (tok_q),
    .depth_limit_i (depth_limit),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        tok_valid_q <= 1'b1;
      end else if (adv) begin
        tok_valid_q <= 1'b0;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tok_q.kind     <= token_kind_i;
      tok_q.map_word <= is_map_word_i;
      tok_q.inc_word <= is_include_word_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign token_role_o = res_q.role;
  assign nest_depth_o = res_q.depth;
  assign status_o     = res_q.status;
  assign finished_o   = res_q.finished;

  // input side only stalls while a token is parked behind a stalled result
  a_stall_needs_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (tok_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled without a parked token");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nest_depth_o <= bctc_pkg::MAX_DEPTH))
    else $error("nesting depth beyond the maximum");

  a_finish_at_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (nest_depth_o == '0))
    else $error("finished while inside a block");

  a_overflow_on_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == bctc_pkg::ST_OVERFLOW)) |->
      (token_role_o == bctc_pkg::ROLE_OPEN))
    else $error("depth overflow on a token that is not an open brace");

  a_halted_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (res_d.status != bctc_pkg::ST_OK)) |=>
      (!adv || (res_d.status == bctc_pkg::ST_IGNORED)))
    else $error("checker resumed after an error");

endmodule

`default_nettype wire
